// ===== sv/ps2_mouse_cursor_tracker_core_defines.svh =====
// Assertion macros shared by the PS/2 cursor tracker RTL.
// No dependencies; every assertion is clocked on clk_i and held off during reset.
`ifndef PS2_MOUSE_CURSOR_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTH
`define PS2MCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PS2MCT_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define PS2MCT_ASSERT(lbl, prop, msg)
`define PS2MCT_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

// ===== sv/ps2mct_pkg.sv =====
// Shared types and constants for the PS/2 mouse cursor tracker.
// No dependencies; every module file imports this package.
package ps2mct_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned CfgW      = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BtnW      = 2;

  localparam logic [CfgW-1:0] ScreenWidthRst  = 13'd1024;
  localparam logic [CfgW-1:0] ScreenHeightRst = 13'd768;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd1;

  // bit positions inside the head byte
  localparam int unsigned BtnLeftBit  = 0;
  localparam int unsigned BtnRightBit = 1;
  localparam int unsigned BtnMidBit   = 2;
  localparam int unsigned HeadMarkBit = 3;
  localparam int unsigned XSignBit    = 4;
  localparam int unsigned YSignBit    = 5;
  localparam int unsigned XOverBit    = 6;
  localparam int unsigned YOverBit    = 7;

  typedef enum logic [BtnW-1:0] {
    BtnNone   = 2'd0,
    BtnRight  = 2'd1,
    BtnMiddle = 2'd2,
    BtnLeft   = 2'd3
  } button_e;

  typedef struct packed {
    logic [CoordBits-1:0] cursor_x;
    logic [CoordBits-1:0] cursor_y;
    logic [BtnW-1:0]      button;
    logic                 packet_done;
  } result_t;

endpackage

// ===== sv/ps2mct_in_reg.sv =====
// Input register stage of the PS/2 cursor tracker: holds one received word.
// Depends on ps2mct_pkg and the shared assertion macros.
`include "ps2_mouse_cursor_tracker_core_defines.svh"

module ps2mct_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ps2mct_pkg::ByteW-1:0] rx_byte_i,
  input  logic                       advance_i,
  output logic                       valid_o,
  output logic [ps2mct_pkg::ByteW-1:0] byte_o
);
  import ps2mct_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  // a held word must not be dropped while the next stage is blocked
  `PS2MCT_ASSERT(a_hold_when_blocked, valid_q && !advance_i |=> valid_q && $stable(byte_q),
                 "input word lost while blocked")

endmodule

// ===== sv/ps2mct_track.sv =====
// Packet assembly, delta decode and cursor clamp of the PS/2 cursor tracker.
// Depends on ps2mct_pkg and the shared assertion macros.
`include "ps2_mouse_cursor_tracker_core_defines.svh"

module ps2mct_track (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ps2mct_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ps2mct_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                          step_i,
  input  logic [ps2mct_pkg::ByteW-1:0]   byte_i,
  output ps2mct_pkg::result_t           result_o
);
  import ps2mct_pkg::*;

  localparam int unsigned MagW = ByteW + 1;
  localparam int unsigned SumW = CoordBits + 3;
  localparam int unsigned HiW  = (CfgW > CoordBits) ? CfgW : CoordBits;
  localparam logic [CoordBits-1:0] CoordMax = '1;
  localparam logic [ByteW-1:0]     OverMag  = '1;

  typedef enum logic [2:0] {
    WaitHead = 3'b001,
    WaitX    = 3'b010,
    WaitY    = 3'b100
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [ByteW-1:0]     head_q, head_d;
  logic [ByteW-1:0]     xdelta_q, xdelta_d;
  logic [CoordBits-1:0] pos_x_q, pos_x_d;
  logic [CoordBits-1:0] pos_y_q, pos_y_d;
  logic [BtnW-1:0]      btn_q, btn_d;
  logic [CfgW-1:0]      width_q, height_q;
  logic                 done;

  logic [MagW-1:0]      mag_x, mag_y;
  logic [SumW-1:0]      x_ext, y_ext, mx_ext, my_ext, x_sum, y_sum;
  logic [CoordBits-1:0] hi_x, hi_y;
  button_e              btn_new;

  // magnitude of one axis: two's-complement negation for a negative delta, plus 255 on overflow
  function automatic logic [MagW-1:0] axis_mag(input logic [ByteW-1:0] b,
                                               input logic neg, input logic over);
    logic [ByteW-1:0] m;
    m = neg ? (ByteW'(0) - b) : b;
    return {1'b0, m} + (over ? {1'b0, OverMag} : MagW'(0));
  endfunction

  function automatic logic [CoordBits-1:0] upper_lim(input logic [CfgW-1:0] size);
    logic [HiW-1:0] m1;
    m1 = HiW'(size) - HiW'(1);
    if (size == '0) begin
      return '0;
    end else if (m1 > HiW'(CoordMax)) begin
      return CoordMax;
    end
    return m1[CoordBits-1:0];
  endfunction

  function automatic logic [CoordBits-1:0] clamp(input logic [SumW-1:0] v,
                                                 input logic [CoordBits-1:0] hi);
    if (v[SumW-1]) begin
      return '0;
    end else if (v > SumW'(hi)) begin
      return hi;
    end
    return v[CoordBits-1:0];
  endfunction

  assign mag_x  = axis_mag(xdelta_q, head_q[XSignBit], head_q[XOverBit]);
  assign mag_y  = axis_mag(byte_i, head_q[YSignBit], head_q[YOverBit]);
  assign x_ext  = SumW'(pos_x_q);
  assign y_ext  = SumW'(pos_y_q);
  assign mx_ext = SumW'(mag_x);
  assign my_ext = SumW'(mag_y);
  // Y moves against the mouse delta
  assign x_sum  = head_q[XSignBit] ? (x_ext - mx_ext) : (x_ext + mx_ext);
  assign y_sum  = head_q[YSignBit] ? (y_ext + my_ext) : (y_ext - my_ext);
  assign hi_x   = upper_lim(width_q);
  assign hi_y   = upper_lim(height_q);

  always_comb begin
    if (head_q[BtnRightBit]) begin
      btn_new = BtnRight;
    end else if (head_q[BtnMidBit]) begin
      btn_new = BtnMiddle;
    end else if (head_q[BtnLeftBit]) begin
      btn_new = BtnLeft;
    end else begin
      btn_new = BtnNone;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    head_d   = head_q;
    xdelta_d = xdelta_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    btn_d    = btn_q;
    done     = 1'b0;
    case (phase_q)
      WaitX: begin
        xdelta_d = byte_i;
        phase_d  = WaitY;
      end
      WaitY: begin
        pos_x_d = clamp(x_sum, hi_x);
        pos_y_d = clamp(y_sum, hi_y);
        btn_d   = btn_new;
        done    = 1'b1;
        phase_d = WaitHead;
      end
      default: begin
        // drop bytes until one carries the head mark
        phase_d = WaitHead;
        if (byte_i[HeadMarkBit]) begin
          head_d  = byte_i;
          phase_d = WaitX;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= WaitHead;
      head_q   <= '0;
      xdelta_q <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      btn_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      head_q   <= head_d;
      xdelta_q <= xdelta_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      btn_q    <= btn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgScreenWidth:  width_q  <= cfg_data_i;
        CfgScreenHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.cursor_x    = pos_x_d;
    result_o.cursor_y    = pos_y_d;
    result_o.button      = btn_d;
    result_o.packet_done = done;
  end

  `PS2MCT_ASSERT(a_done_on_third, step_i && phase_q == WaitY |-> result_o.packet_done,
                 "third byte did not complete a packet")
  `PS2MCT_ASSERT(a_back_to_head, step_i && result_o.packet_done |=> phase_q == WaitHead,
                 "phase did not return to head after a packet")
  `PS2MCT_ASSERT(a_pos_idle, !step_i |=> $stable(pos_x_q) && $stable(pos_y_q),
                 "cursor moved without a byte")

endmodule

// ===== sv/ps2mct_out_reg.sv =====
// Result register of the PS/2 cursor tracker: holds one result word for the sink.
// Depends on ps2mct_pkg and the shared assertion macros.
`include "ps2_mouse_cursor_tracker_core_defines.svh"

module ps2mct_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ps2mct_pkg::result_t result_i,
  input  logic                out_stall_i,
  output logic                advance_o,
  output logic                valid_o,
  output ps2mct_pkg::result_t result_o
);
  import ps2mct_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // room when empty or the held word leaves this cycle
  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  `PS2MCT_ASSERT_NEVER(a_no_overwrite, load_i && valid_q && out_stall_i,
                       "result loaded over a stalled word")

endmodule

// ===== sv/ps2_mouse_cursor_tracker_core.sv =====
// Top level of the PS/2 mouse cursor tracker.
// Depends on ps2mct_pkg, ps2mct_in_reg, ps2mct_track and ps2mct_out_reg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------------
//   input    | in_valid_i / in_stall_o  | rx_byte_i
//   output   | out_valid_o / out_stall_i | cursor_x_o, cursor_y_o, button_o, packet_done_o
//   config   | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One word per cycle sustained while out_stall_i stays low; each word's result reaches the
// outputs through the input register, then the decode/clamp logic into the result register.
// Reset clears the packet phase, cursor and button and loads a 1024 x 768 screen.
// A stalled result holds in the result register; the input register keeps taking
// words until it too holds one the result register cannot take.
module ps2_mouse_cursor_tracker_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ps2mct_pkg::ByteW-1:0]     rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ps2mct_pkg::CoordBits-1:0] cursor_x_o,
  output logic [ps2mct_pkg::CoordBits-1:0] cursor_y_o,
  output logic [ps2mct_pkg::BtnW-1:0]      button_o,
  output logic                            packet_done_o,
  input  logic                            cfg_we_i,
  input  logic [ps2mct_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ps2mct_pkg::CfgW-1:0]      cfg_data_i
);
  import ps2mct_pkg::*;

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             advance;
  logic             step;
  result_t          next_result;
  result_t          out_result;

  assign step = s1_valid && advance;

  ps2mct_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  ps2mct_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .byte_i     (s1_byte),
    .result_o   (next_result)
  );

  ps2mct_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (next_result),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .valid_o     (out_valid_o),
    .result_o    (out_result)
  );

  assign cursor_x_o    = out_result.cursor_x;
  assign cursor_y_o    = out_result.cursor_y;
  assign button_o      = out_result.button;
  assign packet_done_o = out_result.packet_done;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for ps2_mouse_cursor_tracker_core: mouse bytes in, cursor reports out.
// Depends on ps2mct_pkg and the core RTL; it predicts every report and compares field by field.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ps2mct_pkg::*;

  localparam int unsigned StallPct      = 30;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned RandomWords   = 1950;
  localparam int unsigned NumSettings   = 8;
  localparam int          CoordMax      = (1 << CoordBits) - 1;

  // indexes past the register list; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam logic [1:0] PhaseHead   = 2'd0;
  localparam logic [1:0] PhaseXDelta = 2'd1;
  localparam logic [1:0] PhaseYDelta = 2'd2;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [ByteW-1:0]     rx_byte_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CoordBits-1:0] cursor_x_o;
  logic [CoordBits-1:0] cursor_y_o;
  logic [BtnW-1:0]      button_o;
  logic                 packet_done_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [CfgW-1:0]      cfg_data_i  = '0;

  // opening words: dropped heads, button mixes, sign/overflow corners, clamps
  logic [ByteW-1:0] opening_words [26] = '{
    8'h00, 8'hF7,
    8'h09, 8'hFF, 8'h01,
    8'h29, 8'hFF, 8'h00,
    8'h4A, 8'h80, 8'h01,
    8'h3C, 8'h01, 8'h80,
    8'hFF, 8'h00, 8'h00,
    8'h08, 8'hFF, 8'hFF,
    8'hC8, 8'hFF, 8'hFF,
    8'h0D, 8'hFF, 8'h00
  };

  logic [ByteW-1:0] rx_backlog [$];
  result_t          cursor_reports_due [$];
  result_t          due_report;
  logic             idle_en = 1'b1;

  // shadow of the tracker state and its screen registers
  logic [1:0]       phase_q  = PhaseHead;
  logic [ByteW-1:0] head_q   = '0;
  logic [ByteW-1:0] xdelta_q = '0;
  int               cur_x    = 0;
  int               cur_y    = 0;
  button_e          btn_q    = BtnNone;
  logic [CfgW-1:0]  scr_w    = ScreenWidthRst;
  logic [CfgW-1:0]  scr_h    = ScreenHeightRst;

  int unsigned mismatches   = 0;
  int unsigned words_sent   = 0;
  int unsigned reports_seen = 0;
  int unsigned packets_seen = 0;
  int unsigned quiet_cycles = 0;

  ps2_mouse_cursor_tracker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .button_o      (button_o),
    .packet_done_o (packet_done_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int axis_move(logic [ByteW-1:0] b, logic neg, logic ovf);
    int d;
    if (!neg) begin
      d = int'(b);
      if (ovf) d = d + 255;
    end else begin
      // sign set with a zero byte moves by zero
      d = (b == 0) ? 0 : int'(b) - 256;
      if (ovf) d = d - 255;
    end
    return d;
  endfunction

  function automatic int clamp_to_screen(int v, logic [CfgW-1:0] size);
    int hi;
    hi = (size == 0) ? 0 : int'(size) - 1;
    if (hi > CoordMax) hi = CoordMax;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic result_t track_byte(logic [ByteW-1:0] b);
    result_t r;
    r.packet_done = 1'b0;
    case (phase_q)
      PhaseXDelta: begin
        xdelta_q = b;
        phase_q  = PhaseYDelta;
      end
      PhaseYDelta: begin
        cur_x = clamp_to_screen(cur_x + axis_move(xdelta_q, head_q[XSignBit], head_q[XOverBit]),
                                scr_w);
        cur_y = clamp_to_screen(cur_y - axis_move(b, head_q[YSignBit], head_q[YOverBit]), scr_h);
        if (head_q[BtnRightBit]) btn_q = BtnRight;
        else if (head_q[BtnMidBit]) btn_q = BtnMiddle;
        else if (head_q[BtnLeftBit]) btn_q = BtnLeft;
        else btn_q = BtnNone;
        phase_q       = PhaseHead;
        r.packet_done = 1'b1;
      end
      default: begin
        phase_q = PhaseHead;
        if (b[HeadMarkBit]) begin
          head_q  = b;
          phase_q = PhaseXDelta;
        end
      end
    endcase
    r.cursor_x = cur_x[CoordBits-1:0];
    r.cursor_y = cur_y[CoordBits-1:0];
    r.button   = btn_q;
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // driver: predict on acceptance, then present the next word or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cursor_reports_due.push_back(track_byte(rx_byte_i));
        words_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rx_backlog.size() != 0 && !(idle_en && $urandom_range(99) < StallPct)) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted report with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        reports_seen++;
        if (cursor_reports_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected report, expected none, actual x=%0d y=%0d btn=%0d done=%0d",
                   $time, cursor_x_o, cursor_y_o, button_o, packet_done_o);
        end else begin
          due_report = cursor_reports_due.pop_front();
          if (due_report.packet_done) packets_seen++;
          check_field("cursor_x", 32'(due_report.cursor_x), 32'(cursor_x_o));
          check_field("cursor_y", 32'(due_report.cursor_y), 32'(cursor_y_o));
          check_field("button", 32'(due_report.button), 32'(button_o));
          check_field("packet_done", 32'(due_report.packet_done), 32'(packet_done_o));
        end
      end
      out_stall_i <= idle_en && ($urandom_range(99) < StallPct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t ns: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_screen_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgScreenWidth) scr_w = val;
    else if (idx == CfgScreenHeight) scr_h = val;
  endtask

  // hold until every word is in and every report is out, then let the pipe settle
  task automatic wait_quiet();
    while (rx_backlog.size() != 0 || in_valid_i || cursor_reports_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly whole packets with random content, plus stray and lone bytes
  task automatic queue_mouse_traffic(input int n_words);
    int               left;
    logic [ByteW-1:0] hd;
    left = n_words;
    while (left > 0) begin
      if ($urandom_range(99) < 85) begin
        hd = ByteW'($urandom_range(255));
        hd[HeadMarkBit] = 1'b1;
        if ($urandom_range(99) < 75) begin
          hd[XOverBit] = 1'b0;
          hd[YOverBit] = 1'b0;
        end
        rx_backlog.push_back(hd);
        rx_backlog.push_back(ByteW'($urandom_range(255)));
        rx_backlog.push_back(ByteW'($urandom_range(255)));
        left = left - 3;
      end else begin
        rx_backlog.push_back(ByteW'($urandom_range(255)));
        left = left - 1;
      end
    end
  endtask

  initial begin
    logic [CfgW-1:0] w;
    logic [CfgW-1:0] h;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_words[i]) rx_backlog.push_back(opening_words[i]);
    wait_quiet();

    for (int s = 0; s < NumSettings; s++) begin
      case (s)
        0: begin w = 13'd4096; h = 13'd4096; end
        1: begin w = 13'd1;    h = 13'd1;    end
        2: begin w = 13'd0;    h = 13'd0;    end
        3: begin w = 13'h1FFF; h = 13'h1FFF; end
        4: begin w = 13'd640;  h = 13'd480;  end
        5: begin
          w = CfgW'($urandom_range(4096, 1));
          h = CfgW'($urandom_range(4096, 1));
        end
        6: begin w = 13'd4096; h = 13'd1;    end
        default: begin
          w = CfgW'($urandom_range(8191));
          h = CfgW'($urandom_range(8191));
        end
      endcase
      // one setting runs without any idling on either side
      idle_en <= (s != 3);
      write_screen_reg(CfgScreenWidth, w);
      write_screen_reg(CfgScreenHeight, h);
      if (s == 1) begin
        write_screen_reg(CfgSpareA, CfgW'($urandom_range(8191)));
        write_screen_reg(CfgSpareB, 13'h1FFF);
      end
      queue_mouse_traffic(RandomWords / NumSettings);
      wait_quiet();
    end

    $display("run covered %0d mouse words and %0d reports (%0d packets)",
             words_sent, reports_seen, packets_seen);
    $display("across %0d screen settings, extremes and oversized included", NumSettings + 1);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
